[hdl/mec_pkg.sv]
// ----------------------------------------------------------------------------
// mec_pkg: shared types and constants of the escape-time counter
// Field widths, configuration register indices, the point record passed
// from the front end to the iteration engine, and the 32-bit saturator.
// ----------------------------------------------------------------------------
`default_nettype none

package mec_pkg;

  localparam int COL_W   = 10;
  localparam int ROW_W   = 10;
  localparam int CNT_W   = 12;
  localparam int VAL_W   = 32;
  localparam int STEP_W  = 31;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_REAL_ORIGIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_ORIGIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REAL_STEP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAG_STEP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_RADIUS_SQ = 3'd5;

  typedef struct packed {
    logic [COL_W-1:0]        column;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] c_re;
    logic signed [VAL_W-1:0] c_im;
  } point_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[VAL_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/mec_if.sv]
// ----------------------------------------------------------------------------
// mec_if: valid/ready channels of the escape-time counter
// mec_pix_if carries pixel positions in, mec_res_if carries counts out.
// ----------------------------------------------------------------------------
`default_nettype none

interface mec_pix_if;
  logic                      valid;
  logic                      ready;
  logic [mec_pkg::COL_W-1:0] column;
  logic [mec_pkg::ROW_W-1:0] row;

  modport source (output valid, output column, output row, input ready);
  modport sink   (input valid, input column, input row, output ready);
endinterface

interface mec_res_if;
  logic                      valid;
  logic                      ready;
  logic [mec_pkg::COL_W-1:0] column_out;
  logic [mec_pkg::ROW_W-1:0] row_out;
  logic [mec_pkg::CNT_W-1:0] escape_count;

  modport source (output valid, output column_out, output row_out,
                  output escape_count, input ready);
  modport sink   (input valid, input column_out, input row_out,
                  input escape_count, output ready);
endinterface

`default_nettype wire

[hdl/mec_front.sv]
// ----------------------------------------------------------------------------
// mec_front: pixel position to complex point
// Two-stage pipeline: multiply position by step, then add origin and
// saturate. Hands finished points to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  mec_pix_if.sink                                   pixel,
  input  wire logic signed [mec_pkg::VAL_W-1:0]     real_origin,
  input  wire logic signed [mec_pkg::VAL_W-1:0]     imag_origin,
  input  wire logic        [mec_pkg::STEP_W-1:0]    real_step,
  input  wire logic        [mec_pkg::STEP_W-1:0]    imag_step,
  output logic                                      point_valid,
  input  wire logic                                 point_ready,
  output mec_pkg::point_t                           point
);

  localparam int PROD_W = mec_pkg::COL_W + mec_pkg::STEP_W;

  logic                      v1;
  logic [mec_pkg::COL_W-1:0] col1;
  logic [mec_pkg::ROW_W-1:0] row1;
  logic [PROD_W-1:0]         p_re;
  logic [PROD_W-1:0]         p_im;
  logic                      adv1;
  logic                      adv2;
  logic signed [63:0]        sum_re;
  logic signed [63:0]        sum_im;

  assign adv2        = !point_valid || point_ready;
  assign adv1        = !v1 || adv2;
  assign pixel.ready = adv1;

  assign sum_re = 64'(real_origin) + $signed(64'(p_re));
  assign sum_im = 64'(imag_origin) + $signed(64'(p_im));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= pixel.valid;
      end
      if (adv2) begin
        point_valid <= v1;
      end
    end
    if (adv1) begin
      col1 <= pixel.column;
      row1 <= pixel.row;
      p_re <= PROD_W'(pixel.column) * PROD_W'(real_step);
      p_im <= PROD_W'(pixel.row) * PROD_W'(imag_step);
    end
    if (adv2) begin
      point.column <= col1;
      point.row    <= row1;
      point.c_re   <= mec_pkg::sat32(sum_re);
      point.c_im   <= mec_pkg::sat32(sum_im);
    end
  end

endmodule

`default_nettype wire

[hdl/mec_queue.sv]
// ----------------------------------------------------------------------------
// mec_queue: short point queue
// Decouples the front end from the iteration engine so either may stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire mec_pkg::point_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output mec_pkg::point_t      out_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  mec_pkg::point_t   entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              push;
  logic              pop;

  assign in_ready  = (fill != FULL);
  assign out_valid = (fill != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

`default_nettype wire

[hdl/mec_back.sv]
// ----------------------------------------------------------------------------
// mec_back: escape-time iteration engine
// Iterates z = z*z + c on one point at a time; each step is a multiply
// state, then a scale, saturate, test and add state. Holds the result in an
// output register until it is transferred.
// ----------------------------------------------------------------------------
`default_nettype none

module mec_back #(
  parameter int FRACTION_BITS = 28
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              point_valid,
  output logic                                   point_ready,
  input  wire mec_pkg::point_t                   point,
  input  wire logic [mec_pkg::CNT_W-1:0]         iteration_limit,
  input  wire logic [mec_pkg::STEP_W-1:0]        escape_radius_sq,
  mec_res_if.source                              result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                        state;
  logic [mec_pkg::COL_W-1:0]         col;
  logic [mec_pkg::ROW_W-1:0]         row;
  logic signed [mec_pkg::VAL_W-1:0]  c_re;
  logic signed [mec_pkg::VAL_W-1:0]  c_im;
  logic signed [mec_pkg::VAL_W-1:0]  x;
  logic signed [mec_pkg::VAL_W-1:0]  y;
  logic [mec_pkg::CNT_W-1:0]         count;
  logic signed [63:0]                pxx;
  logic signed [63:0]                pyy;
  logic signed [63:0]                pxy;
  logic signed [mec_pkg::VAL_W-1:0]  x2;
  logic signed [mec_pkg::VAL_W-1:0]  y2;
  logic signed [mec_pkg::VAL_W-1:0]  xy;
  logic signed [mec_pkg::VAL_W:0]    mag;
  logic                              inside_r;
  logic signed [mec_pkg::VAL_W-1:0]  x_next;
  logic signed [mec_pkg::VAL_W-1:0]  y_next;

  assign point_ready = (state == ST_IDLE);

  always_comb begin
    x2       = mec_pkg::sat32(pxx >>> FRACTION_BITS);
    y2       = mec_pkg::sat32(pyy >>> FRACTION_BITS);
    xy       = mec_pkg::sat32(pxy >>> FRACTION_BITS);
    mag      = {x2[mec_pkg::VAL_W-1], x2} + {y2[mec_pkg::VAL_W-1], y2};
    inside_r = mag < $signed({2'b00, escape_radius_sq});
    x_next   = mec_pkg::sat32(64'(x2) - 64'(y2) + 64'(c_re));
    y_next   = mec_pkg::sat32((64'(xy) <<< 1) + 64'(c_im));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result.valid <= 1'b0;
    end else begin
      if (state == ST_FIN && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (point_valid) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (count >= iteration_limit) begin
            state <= ST_FIN;
          end else begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          state <= inside_r ? ST_MUL : ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!result.valid || result.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end

    case (state)
      ST_IDLE: begin
        col   <= point.column;
        row   <= point.row;
        c_re  <= point.c_re;
        c_im  <= point.c_im;
        x     <= point.c_re;
        y     <= point.c_im;
        count <= '0;
      end
      ST_MUL: begin
        pxx <= 64'(x) * 64'(x);
        pyy <= 64'(y) * 64'(y);
        pxy <= 64'(x) * 64'(y);
      end
      ST_UPD: begin
        if (inside_r) begin
          x     <= x_next;
          y     <= y_next;
          count <= count + mec_pkg::CNT_W'(1);
        end
      end
      ST_FIN: begin
        if (!result.valid || result.ready) begin
          result.column_out   <= col;
          result.row_out      <= row;
          result.escape_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/mandelbrot_escape_counter.sv]
// ----------------------------------------------------------------------------
// mandelbrot_escape_counter: escape-time count for one pixel per item
// Pixel positions arrive on the pixel channel, counts leave on the result
// channel, each a valid/ready transfer. The write port sets origin, step,
// iteration limit and squared escape radius (Q4.28); write it only while
// no pixel is in flight.
// The front end turns a position into c in its multiply and add-and-saturate
// stages and pushes it into a short queue, so it keeps accepting pixels while
// the engine is busy. The engine takes one point at a time and runs each
// iteration as the multiplier set, then saturate, test and add; it stops
// when a point escapes or its count reaches the iteration limit, which is
// 256 by default.
// A stalled receiver holds the result register; the engine then waits with
// the next result and the queue fills, after which the pixel channel drops
// ready. Reset empties the pipeline and queue and loads the default
// registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_counter #(
  parameter int FRACTION_BITS = 28,
  parameter int QUEUE_DEPTH   = 4
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                wr_en,
  input  wire logic [mec_pkg::CFG_IDX_W-1:0]       wr_index,
  input  wire logic [mec_pkg::CFG_DATA_W-1:0]      wr_data,
  mec_pix_if.sink                                  pixel,
  mec_res_if.source                                result
);

  logic signed [mec_pkg::VAL_W-1:0]  real_origin;
  logic signed [mec_pkg::VAL_W-1:0]  imag_origin;
  logic        [mec_pkg::STEP_W-1:0] real_step;
  logic        [mec_pkg::STEP_W-1:0] imag_step;
  logic        [mec_pkg::CNT_W-1:0]  iteration_limit;
  logic        [mec_pkg::STEP_W-1:0] escape_radius_sq;

  logic            f_valid;
  logic            f_ready;
  mec_pkg::point_t f_point;
  logic            q_valid;
  logic            q_ready;
  mec_pkg::point_t q_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      real_origin      <= -32'sd536870912;
      imag_origin      <= -32'sd268435456;
      real_step        <= 31'd786432;
      imag_step        <= 31'd786432;
      iteration_limit  <= 12'd256;
      escape_radius_sq <= 31'd1073741824;
    end else if (wr_en) begin
      case (wr_index)
        mec_pkg::CFG_REAL_ORIGIN:      real_origin      <= wr_data;
        mec_pkg::CFG_IMAG_ORIGIN:      imag_origin      <= wr_data;
        mec_pkg::CFG_REAL_STEP:        real_step        <= wr_data[mec_pkg::STEP_W-1:0];
        mec_pkg::CFG_IMAG_STEP:        imag_step        <= wr_data[mec_pkg::STEP_W-1:0];
        mec_pkg::CFG_ITERATION_LIMIT:  iteration_limit  <= wr_data[mec_pkg::CNT_W-1:0];
        mec_pkg::CFG_ESCAPE_RADIUS_SQ: escape_radius_sq <= wr_data[mec_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mec_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pixel       (pixel),
    .real_origin (real_origin),
    .imag_origin (imag_origin),
    .real_step   (real_step),
    .imag_step   (imag_step),
    .point_valid (f_valid),
    .point_ready (f_ready),
    .point       (f_point)
  );

  mec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_point),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_point)
  );

  mec_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .point_valid      (q_valid),
    .point_ready      (q_ready),
    .point            (q_point),
    .iteration_limit  (iteration_limit),
    .escape_radius_sq (escape_radius_sq),
    .result           (result)
  );

endmodule

`default_nettype wire
